// ===== rtl/rdf_pkg.sv =====
// Shared types and constants for the radix digit formatter.
package rdf_pkg;

	localparam int IN_BITS = 32;
	localparam int VALUE_BITS_DEF = 32;
	localparam int MAX_PRECISION = 64;
	localparam int PREC_BITS = 7;
	localparam int CHAR_BITS = 6;
	localparam int COUNT_BITS = 32;

	// Reciprocal of ten for a 32-bit dividend; the quotient is the product shifted by 35.
	localparam logic [63:0] RECIP10 = 64'h0000_0000_CCCC_CCCD;
	localparam int RECIP10_SHIFT = 35;

	localparam logic [CHAR_BITS-1:0] CHAR_ZERO = 6'd48;

	typedef enum logic [1:0] {
		RADIX_BIN = 2'd0,
		RADIX_OCT = 2'd1,
		RADIX_DEC = 2'd2
	} radix_t;

	typedef struct packed {
		logic busy;
		logic done;
	} rdf_conv_status_t;

endpackage

// ===== rtl/rdf_item_if.sv =====
// Input channel carrying one number to format.
interface rdf_item_if;
	import rdf_pkg::*;

	logic valid;
	logic ready;
	logic [IN_BITS-1:0] value;
	logic [1:0] radix_mode;
	logic precision_given;
	logic [PREC_BITS-1:0] min_digits;

	modport source (output valid, value, radix_mode, precision_given, min_digits, input ready);
	modport sink (input valid, value, radix_mode, precision_given, min_digits, output ready);

endinterface

// ===== rtl/rdf_result_if.sv =====
// Output channel carrying one ASCII character per transaction.
interface rdf_result_if;
	import rdf_pkg::*;

	logic valid;
	logic ready;
	logic [CHAR_BITS-1:0] character;
	logic last_char;
	logic [COUNT_BITS-1:0] total_chars;

	modport source (output valid, character, last_char, total_chars, input ready);
	modport sink (input valid, character, last_char, total_chars, output ready);

endinterface

// ===== rtl/rdf_div_unit.sv =====
// Shared divide-by-radix unit that peels off one digit per step, least significant first.
module rdf_div_unit import rdf_pkg::*; #(
	parameter int VALUE_BITS = VALUE_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic [((VALUE_BITS < IN_BITS) ? VALUE_BITS : IN_BITS)-1:0] value_in,
	input  radix_t radix_in,
	output rdf_conv_status_t status,
	output logic [$clog2(VALUE_BITS+1)-1:0] digit_count,
	output logic wr_en,
	output logic [$clog2(VALUE_BITS)-1:0] wr_addr,
	output logic [3:0] wr_digit
);

	localparam int VW = (VALUE_BITS < IN_BITS) ? VALUE_BITS : IN_BITS;
	localparam int AW = $clog2(VALUE_BITS);
	localparam int CW = $clog2(VALUE_BITS+1);
	localparam int QW = 64 - RECIP10_SHIFT;

	logic busy_q;
	logic phase_q;
	logic [CW-1:0] n_q;
	radix_t radix_q;
	logic [VW-1:0] v_q;
	logic [63:0] prod_q;

	logic fin;
	logic adv;
	logic [VW-1:0] v_nxt;
	logic [QW-1:0] quo;
	logic [IN_BITS-1:0] quo_x10;
	logic [3:0] rem;

	always_comb begin
		fin = (v_q == '0) || (n_q == CW'(VALUE_BITS));
		quo = prod_q[63:RECIP10_SHIFT];
		quo_x10 = (IN_BITS'(quo) << 3) + (IN_BITS'(quo) << 1);
		// The remainder is below ten, so four bits of the difference suffice.
		rem = v_q[3:0] - quo_x10[3:0];
		wr_en = 1'b0;
		wr_addr = n_q[AW-1:0];
		wr_digit = '0;
		adv = 1'b0;
		v_nxt = v_q;
		if (busy_q) begin
			if (fin) begin
				// A value of zero still gives the single digit zero.
				wr_en = (n_q == '0);
			end else begin
				case (radix_q)
					RADIX_BIN: begin
						wr_en = 1'b1;
						wr_digit = {3'b000, v_q[0]};
						v_nxt = v_q >> 1;
						adv = 1'b1;
					end
					RADIX_OCT: begin
						wr_en = 1'b1;
						wr_digit = {1'b0, v_q[2:0]};
						v_nxt = v_q >> 3;
						adv = 1'b1;
					end
					default: begin
						if (phase_q) begin
							wr_en = 1'b1;
							wr_digit = rem;
							v_nxt = VW'(quo);
							adv = 1'b1;
						end
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			phase_q <= 1'b0;
			n_q <= '0;
			radix_q <= RADIX_BIN;
		end else if (start) begin
			busy_q <= 1'b1;
			phase_q <= 1'b0;
			n_q <= '0;
			radix_q <= radix_in;
		end else if (busy_q) begin
			if (fin) begin
				busy_q <= 1'b0;
				if (n_q == '0) begin
					n_q <= CW'(1);
				end
			end else if (adv) begin
				n_q <= n_q + CW'(1);
				phase_q <= 1'b0;
			end else begin
				phase_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			v_q <= value_in;
		end else if (adv) begin
			v_q <= v_nxt;
		end
		if (busy_q && !phase_q) begin
			prod_q <= 64'(IN_BITS'(v_q)) * RECIP10;
		end
	end

	assign status.busy = busy_q;
	assign status.done = busy_q && fin;
	assign digit_count = n_q;

endmodule

// ===== rtl/radix_digit_formatter.sv =====
// Top level: converts an unsigned number to ASCII digits in base 2, 8 or 10, most significant first.
// Sequence: the divide unit writes the digits, a setup state reads the top one and sets the pad count,
// then one character per cycle goes out while taken, pad zeros first.
// A new number is not taken until the last one is through: the input is not ready until the last character
// has entered the output register.
// Reset: arst_n clears the sequencer, output valid and the running count; the digit store is not cleared.
module radix_digit_formatter import rdf_pkg::*; #(
	parameter int VALUE_BITS = VALUE_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	rdf_item_if.sink item,
	rdf_result_if.source result
);

	localparam int VW = (VALUE_BITS < IN_BITS) ? VALUE_BITS : IN_BITS;
	localparam int AW = $clog2(VALUE_BITS);
	localparam int CW = $clog2(VALUE_BITS+1);

	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_CONV  = 5'b00010,
		S_PREP  = 5'b00100,
		S_PAD   = 5'b01000,
		S_DIGIT = 5'b10000
	} state_t;

	state_t state_q, state_d;
	logic [PREC_BITS-1:0] prec_q, prec_in;
	logic [PREC_BITS-1:0] pad_q, pad_d, pad_calc;
	logic [AW-1:0] idx_q, idx_d;

	logic item_fire;
	radix_t radix_in;
	rdf_conv_status_t conv_stat;
	logic [CW-1:0] digit_count;
	logic [CW-1:0] count_m1;
	logic wr_en;
	logic [AW-1:0] wr_addr;
	logic [3:0] wr_digit;

	logic [3:0] digit_mem [VALUE_BITS];
	logic rd_en;
	logic [AW-1:0] rd_addr;
	logic [3:0] rd_data_q;

	logic slot_free;
	logic ld_out;
	logic [CHAR_BITS-1:0] ld_char;
	logic ld_last;
	logic out_valid_q;
	logic [CHAR_BITS-1:0] char_q;
	logic last_q;
	logic [COUNT_BITS-1:0] total_q;

	assign item.ready = (state_q == S_IDLE);
	assign item_fire = item.valid && item.ready;

	always_comb begin
		case (item.radix_mode)
			RADIX_BIN: radix_in = RADIX_BIN;
			RADIX_OCT: radix_in = RADIX_OCT;
			default: radix_in = RADIX_DEC;
		endcase
		if (!item.precision_given) begin
			prec_in = '0;
		end else if (item.min_digits > PREC_BITS'(MAX_PRECISION)) begin
			prec_in = PREC_BITS'(MAX_PRECISION);
		end else begin
			prec_in = item.min_digits;
		end
	end

	rdf_div_unit #(
		.VALUE_BITS(VALUE_BITS)
	) u_div (
		.clk(clk),
		.arst_n(arst_n),
		.start(item_fire),
		.value_in(item.value[VW-1:0]),
		.radix_in(radix_in),
		.status(conv_stat),
		.digit_count(digit_count),
		.wr_en(wr_en),
		.wr_addr(wr_addr),
		.wr_digit(wr_digit)
	);

	// Digit store: written by the divide unit, read one digit ahead of the output register.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			digit_mem[wr_addr] <= wr_digit;
		end
		if (rd_en) begin
			rd_data_q <= digit_mem[rd_addr];
		end
	end

	assign slot_free = !out_valid_q || result.ready;
	assign count_m1 = digit_count - CW'(1);
	assign pad_calc = (prec_q > PREC_BITS'(digit_count)) ?
		(prec_q - PREC_BITS'(digit_count)) : '0;

	always_comb begin
		state_d = state_q;
		pad_d = pad_q;
		idx_d = idx_q;
		rd_en = 1'b0;
		rd_addr = idx_q;
		ld_out = 1'b0;
		ld_char = CHAR_ZERO;
		ld_last = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (item_fire) begin
					state_d = S_CONV;
				end
			end
			S_CONV: begin
				if (conv_stat.done) begin
					state_d = S_PREP;
				end
			end
			S_PREP: begin
				rd_en = 1'b1;
				rd_addr = count_m1[AW-1:0];
				idx_d = count_m1[AW-1:0];
				pad_d = pad_calc;
				state_d = (pad_calc != '0) ? S_PAD : S_DIGIT;
			end
			S_PAD: begin
				if (slot_free) begin
					ld_out = 1'b1;
					pad_d = pad_q - PREC_BITS'(1);
					if (pad_q == PREC_BITS'(1)) begin
						state_d = S_DIGIT;
					end
				end
			end
			S_DIGIT: begin
				if (slot_free) begin
					ld_out = 1'b1;
					ld_char = CHAR_ZERO | {2'b00, rd_data_q};
					if (idx_q == '0) begin
						ld_last = 1'b1;
						state_d = S_IDLE;
					end else begin
						// Fetch the next lower digit while this one goes out.
						idx_d = idx_q - AW'(1);
						rd_en = 1'b1;
						rd_addr = idx_q - AW'(1);
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			pad_q <= '0;
			out_valid_q <= 1'b0;
			total_q <= '0;
		end else begin
			state_q <= state_d;
			pad_q <= pad_d;
			if (ld_out) begin
				out_valid_q <= 1'b1;
				total_q <= total_q + COUNT_BITS'(1);
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		idx_q <= idx_d;
		if (item_fire) begin
			prec_q <= prec_in;
		end
		if (ld_out) begin
			char_q <= ld_char;
			last_q <= ld_last;
		end
	end

	assign result.valid = out_valid_q;
	assign result.character = char_q;
	assign result.last_char = last_q;
	assign result.total_chars = total_q;

	a_start_conv: assert property (@(posedge clk) disable iff (!arst_n)
		item_fire |=> conv_stat.busy && (state_q == S_CONV))
		else $error("conversion did not start after an accepted transaction");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		ld_out |=> total_q == $past(total_q) + COUNT_BITS'(1))
		else $error("character count did not advance by one");

	a_last_flag: assert property (@(posedge clk) disable iff (!arst_n)
		ld_out && (state_q == S_DIGIT) && (idx_q == '0) |=> result.valid && result.last_char)
		else $error("final digit left without its last flag");

	a_pad_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_PAD) |-> (pad_q != '0))
		else $error("padding state entered with no pad characters left");

endmodule
